>>> rtl/pfe_pkg.sv
// shared constants and types for the polarized fractal efficiency block
`default_nettype none
package pfe_pkg;
  localparam int MaxWindow = 64;
  localparam int PriceDepth = MaxWindow + 1;
  localparam int PriceAw = $clog2(PriceDepth);
  localparam int StepAw = $clog2(MaxWindow);
  localparam int SumW = 40;
  localparam int SqrtSteps = 32;
  localparam int DivSteps = 55;
  localparam int DivPreShift = 64 - DivSteps;

  localparam logic [6:0] WindowReset = 7'd10;
  localparam logic [16:0] WeightReset = 17'd21845;
  localparam logic [63:0] StepBias = 64'd65536;
  localparam logic [63:0] RootBias = 64'd6553600;
  localparam logic [22:0] RatioScale = 23'd6553600;

  localparam logic CfgWindow = 1'b0;
  localparam logic CfgWeight = 1'b1;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_cmd_t;
endpackage
`default_nettype wire

>>> rtl/pfe_ram.sv
// simple one write, one registered read port memory
`default_nettype none
module pfe_ram #(
  parameter int Depth = 64,
  parameter int Width = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/pfe_iter.sv
// shared shift-subtract unit: integer square root or restoring division
`default_nettype none
module pfe_iter import pfe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire iter_cmd_t        cmd_i,
  input  wire logic [63:0]      op_a_i,
  input  wire logic [SumW-1:0]  op_b_i,
  output logic                  done_o,
  output logic      [63:0]      res_o
);
  logic [5:0]      cnt_q, cnt_d;
  logic            div_q, done_q;
  logic [63:0]     acc_q, acc_d, res_q, res_d;
  logic [SumW-1:0] rem_q, rem_d, b_q, rem_sh, trial;
  logic            ge;

  always_comb begin
    if (div_q) begin
      rem_sh = {rem_q[SumW-2:0], acc_q[63]};
      trial  = b_q;
    end else begin
      rem_sh = {rem_q[SumW-3:0], acc_q[63:62]};
      trial  = {res_q[SumW-3:0], 2'b01};
    end
    ge    = rem_sh >= trial;
    rem_d = ge ? rem_sh - trial : rem_sh;
    res_d = {res_q[62:0], ge};
    acc_d = div_q ? {acc_q[62:0], 1'b0} : {acc_q[61:0], 2'b00};
    cnt_d = cnt_q - 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        div_q <= cmd_i.is_div;
        cnt_q <= cmd_i.is_div ? 6'(DivSteps) : 6'(SqrtSteps);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_d;
        done_q <= cnt_q == 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= cmd_i.is_div ? (op_a_i << DivPreShift) : op_a_i;
      b_q   <= op_b_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire

>>> rtl/polarized_fractal_efficiency_top.sv
// polarized fractal efficiency, EMA smoothed, one price word in, one result word out
// Usage:
//   s_axis carries one Q24.8 price word per transfer; m_axis returns the
//   smoothed efficiency in Q15.16. The first W words after reset or after a
//   window_length write give no result; every later word gives one.
//   cfg_we_i writes window_length (index 0) or smoothing_weight (index 1);
//   writing the window restarts warmup, the weight leaves state alone.
//   From acceptance to result a word runs two 32-step square roots and one
//   55-step division one after another on the single shift-subtract unit,
//   plus a multiply stage around each of them and the memory reads. In
//   warmup the first word is only stored, the rest run just the first root.
//   s_axis_tready is high only while the sequencer is idle, so one word is
//   in work at a time. The result sits in an output register; the next word
//   is accepted while it waits, and the sequencer only holds at its output
//   step if the previous result has not yet been taken.
//   Reset sets the control state, configuration, step sum and EMA; other
//   datapath registers and the price and step memories are not cleared,
//   warmup ensures the memories are written before they are read.
`default_nettype none
module polarized_fractal_efficiency_top import pfe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] price_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [31:0] pfe_value
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StPrev = 4'd1;
  localparam logic [3:0] StSq1  = 4'd2;
  localparam logic [3:0] StRun1 = 4'd3;
  localparam logic [3:0] StMul2 = 4'd4;
  localparam logic [3:0] StRun2 = 4'd5;
  localparam logic [3:0] StMul3 = 4'd6;
  localparam logic [3:0] StRun3 = 4'd7;
  localparam logic [3:0] StEma  = 4'd8;
  localparam logic [3:0] StEma2 = 4'd9;
  localparam logic [3:0] StOut  = 4'd10;
  localparam logic [3:0] StFin  = 4'd11;

  logic [3:0]         state_q;
  logic [6:0]         win_q, w_eff;
  logic [16:0]        weight_q;
  logic [6:0]         warm_q, rp_q;
  logic [StepAw-1:0]  sp_q, sp_next;
  logic [SumW-1:0]    sum_q;
  logic signed [31:0] ema_q, p_q, old_q, ratio_q, out_q;
  logic               out_valid_q, neg_q;
  logic [63:0]        op_q;
  logic signed [51:0] prod_q;

  logic [PriceAw-1:0] prev_addr, old_addr, p_raddr;
  logic [31:0]        p_rdata, s_rdata, step_val;
  logic               s_we, accept, full;
  iter_cmd_t          cmd;
  logic               it_done;
  logic [63:0]        it_res;

  always_comb begin
    if (win_q == 7'd0) w_eff = 7'd1;
    else if (win_q > 7'(MaxWindow)) w_eff = 7'(MaxWindow);
    else w_eff = win_q;
  end

  assign prev_addr = PriceAw'((rp_q == 7'd0) ? w_eff : rp_q - 7'd1);
  assign old_addr  = PriceAw'((rp_q == w_eff) ? 7'd0 : rp_q + 7'd1);
  assign p_raddr   = (state_q == StIdle) ? prev_addr : old_addr;
  assign sp_next   = ({1'b0, sp_q} + 7'd1 >= w_eff) ? '0 : sp_q + StepAw'(1);
  assign full      = warm_q >= w_eff;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == StIdle;

  function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    abs_diff = d[32] ? 32'(-d) : d[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [36:0] v);
    if (v > 37'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -37'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  pfe_ram #(.Depth(PriceDepth), .Width(32), .AddrW(PriceAw)) u_price (
    .clk_i, .we_i(accept), .waddr_i(PriceAw'(rp_q)), .wdata_i(s_axis_tdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  assign step_val = it_res[31:0];
  assign s_we = (state_q == StRun1) && it_done;

  pfe_ram #(.Depth(MaxWindow), .Width(32), .AddrW(StepAw)) u_step (
    .clk_i, .we_i(s_we), .waddr_i(sp_q), .wdata_i(step_val),
    .raddr_i(sp_next), .rdata_o(s_rdata)
  );

  assign cmd.start  = state_q == StSq1 || state_q == StMul2 || state_q == StMul3;
  assign cmd.is_div = state_q == StMul3;

  pfe_iter u_iter (
    .clk_i, .rst_ni, .cmd_i(cmd), .op_a_i(op_q), .op_b_i(sum_q),
    .done_o(it_done), .res_o(it_res)
  );

  // ratio from the quotient: clamp, sign, saturate
  logic [31:0]        q_mag;
  logic signed [32:0] ratio_w;
  always_comb begin
    q_mag   = (it_res > 64'h8000_0000) ? 32'h8000_0000 : it_res[31:0];
    ratio_w = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      win_q       <= WindowReset;
      weight_q    <= WeightReset;
      warm_q      <= '0;
      rp_q        <= '0;
      sp_q        <= '0;
      sum_q       <= '0;
      ema_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StOut && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgWindow: begin
            win_q  <= cfg_data_i[6:0];
            warm_q <= '0;
            rp_q   <= '0;
            sp_q   <= '0;
            sum_q  <= '0;
          end
          CfgWeight: weight_q <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        StIdle: if (accept) begin
          if (warm_q == '0) begin
            rp_q   <= (rp_q == w_eff) ? 7'd0 : rp_q + 7'd1;
            warm_q <= 7'd1;
          end else begin
            state_q <= StPrev;
          end
        end
        StPrev: state_q <= StSq1;
        StSq1:  state_q <= StRun1;
        StRun1: if (it_done) begin
          sum_q   <= sum_q + SumW'(step_val);
          state_q <= full ? StMul2 : StFin;
        end
        StMul2: state_q <= StRun2;
        StRun2: if (it_done) state_q <= StMul3;
        StMul3: state_q <= StRun3;
        StRun3: if (it_done) state_q <= StEma;
        StEma:  state_q <= (warm_q == w_eff) ? StOut : StEma2;
        StEma2: begin
          ema_q   <= sat32(37'(ema_q) + 37'(prod_q >>> 16));
          state_q <= StOut;
        end
        StOut: if (!out_valid_q || m_axis_tready) begin
          sum_q       <= sum_q - SumW'(s_rdata);
          state_q     <= StFin;
        end
        StFin: begin
          sp_q    <= sp_next;
          rp_q    <= (rp_q == w_eff) ? 7'd0 : rp_q + 7'd1;
          if (warm_q < w_eff + 7'd1) warm_q <= warm_q + 7'd1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if (state_q == StEma && warm_q == w_eff) ema_q <= ratio_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) p_q <= s_axis_tdata;
    if (state_q == StPrev) op_q <= 64'(abs_diff(p_q, p_rdata)) * 64'(abs_diff(p_q, p_rdata)) + StepBias;
    if (state_q == StSq1) begin
      old_q <= p_rdata;
      neg_q <= !(p_q > $signed(p_rdata));
    end
    if (state_q == StRun1 && it_done)
      op_q <= 64'(abs_diff(p_q, old_q)) * 64'(abs_diff(p_q, old_q)) + RootBias;
    if (state_q == StRun2 && it_done) op_q <= 64'(it_res[31:0] * 55'(RatioScale));
    if (state_q == StRun3 && it_done) ratio_q <= sat32(37'(ratio_w));
    if (state_q == StEma) prod_q <= (52'(ratio_q) - 52'(ema_q)) * $signed({35'd0, weight_q});
    if (state_q == StOut && (!out_valid_q || m_axis_tready)) out_q <= ema_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

>>> rtl/pfe_checker.sv
// port-level checks for the polarized fractal efficiency block
`default_nettype none
module pfe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a valid result word carries known data
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown(m_axis_tdata))
    else $error("result word carries unknown bits");

  // a new result only appears while the sequencer is busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work");
endmodule

bind polarized_fractal_efficiency_top pfe_checker u_pfe_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for the polarized fractal efficiency block
`default_nettype none
module tb import pfe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 8000;
  localparam int SettleCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgWindow;
  logic [16:0] cfg_data_i = '0;

  polarized_fractal_efficiency_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [6:0]  win_cfg;
  logic [16:0] weight_cfg;
  longint      price_ring [0:MaxWindow];
  logic [63:0] step_ring [0:MaxWindow-1];
  logic [63:0] len_sum;
  longint      ema;
  int          warm, rpos, spos;

  logic [31:0] pfe_expected [$];
  int          errors = 0;
  int          words_in = 0, words_out = 0, cfg_writes = 0;
  int          quiet = 0;
  int          rx_hold = 0;
  bit          idle_on = 1'b1;
  logic [31:0] last_price = '0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs_gap(longint a, longint b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // advances the predictor by one price word, pushes a result when one is due
  function automatic void predict_pfe(logic [31:0] raw);
    int w, prev_slot, old_slot, leave_slot;
    longint p, old, ratio, delta;
    logic [63:0] d, stp, root, q;
    w = win_cfg;
    if (w < 1) w = 1;
    if (w > MaxWindow) w = MaxWindow;
    if (rpos > w) rpos = 0;
    if (spos >= w) spos = 0;
    p = longint'($signed(raw));
    price_ring[rpos] = p;
    if (warm >= 1) begin
      prev_slot = (rpos == 0) ? w : rpos - 1;
      d = abs_gap(p, price_ring[prev_slot]);
      stp = int_sqrt(d * d + StepBias);
      step_ring[spos] = stp;
      len_sum += stp;
      if (warm >= w) begin
        old_slot = (rpos == w) ? 0 : rpos + 1;
        old = price_ring[old_slot];
        d = abs_gap(p, old);
        root = int_sqrt(d * d + RootBias);
        q = (root * 64'd6553600) / len_sum;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        ratio = clip32((p > old) ? longint'(q) : -longint'(q));
        if (warm == w) begin
          ema = ratio;
        end else begin
          delta = (ratio - ema) * longint'(weight_cfg);
          ema = clip32(ema + (delta >>> 16));
        end
        pfe_expected.push_back(ema[31:0]);
        leave_slot = (spos + 1 >= w) ? 0 : spos + 1;
        len_sum -= step_ring[leave_slot];
      end
      spos = (spos + 1 >= w) ? 0 : spos + 1;
    end
    rpos = (rpos == w) ? 0 : rpos + 1;
    if (warm < w + 1) warm++;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (pfe_expected.size() == 0) begin
        report("unexpected result", m_axis_tdata, '0);
      end else begin
        want = pfe_expected.pop_front();
        if (m_axis_tdata !== want) report("pfe_value", m_axis_tdata, want);
      end
    end
  end

  // receiver: random stall bursts, plus a long hold when asked
  always @(posedge clk_i) begin
    static int stall = 0;
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else if (stall > 0) begin
      m_axis_tready <= 1'b0;
      stall--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall = $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_price(logic [31:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pfe(v);
    last_price = v;
    words_in++;
  endtask

  // waits until the block is idle, then writes one register
  task automatic write_reg(logic idx, logic [16:0] val);
    s_axis_tvalid <= 1'b0;
    wait (pfe_expected.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    if (idx == CfgWindow) begin
      win_cfg = val[6:0];
      warm = 0;
      rpos = 0;
      spos = 0;
      len_sum = 0;
    end else begin
      weight_cfg = val;
    end
  endtask

  function automatic logic [31:0] next_price();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return last_price + 32'($signed($urandom_range(0, 4000)) - 2000);
  endfunction

  task automatic test_extremes();
    logic [31:0] vals [] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
      32'h7fff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 32'h1, 32'h100, 32'h100,
      32'hffff_ff00, 32'h7fff_ffff, 32'h8000_0000, 32'h0};
    foreach (vals[i]) send_price(vals[i]);
  endtask

  task automatic test_window_edges();
    write_reg(CfgWindow, 17'd1);
    repeat (5) send_price($urandom);
    write_reg(CfgWindow, 17'd0);
    repeat (3) send_price(32'h55);
    write_reg(CfgWindow, 17'd3);
  endtask

  task automatic test_weight_edges();
    write_reg(CfgWeight, 17'd0);
    repeat (6) send_price(next_price());
    write_reg(CfgWeight, 17'h1ffff);
    repeat (6) send_price($urandom);
    write_reg(CfgWeight, 17'd65536);
    repeat (4) send_price(next_price());
  endtask

  task automatic test_backpressure();
    write_reg(CfgWindow, 17'd2);
    rx_hold = 2500;
    repeat (12) send_price(next_price());
  endtask

  task automatic test_random();
    logic [6:0]  wins [] = '{7'd64, 7'd127, 7'd1, 7'd5, 7'd10, 7'd20, 7'd2, 7'd33};
    logic [16:0] wts  [] = '{17'd1, 17'd21845, 17'd65535, 17'd300, 17'd40000,
      17'd8000, 17'd1, 17'd30000};
    foreach (wins[i]) begin
      if (i == wins.size() - 2) idle_on = 1'b0;
      write_reg(CfgWindow, {10'd0, wins[i]});
      write_reg(CfgWeight, wts[i]);
      repeat (105) send_price(next_price());
    end
  endtask

  initial begin
    win_cfg = WindowReset;
    weight_cfg = WeightReset;
    len_sum = 0;
    ema = 0;
    warm = 0;
    rpos = 0;
    spos = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_window_edges();
    test_weight_edges();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    wait (pfe_expected.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("run: %0d price words in, %0d results out, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("covered extreme prices, window 0/1/64/127, weights 0 to above 1.0, long stall");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/pfe_pkg.sv
rtl/pfe_ram.sv
rtl/pfe_iter.sv
rtl/polarized_fractal_efficiency_top.sv
rtl/pfe_checker.sv
dv/tb.sv
